// ----- hw/rtl/lwd_pkg.sv -----
// Package for the LZSS window decompressor: shared types, phase and status codes.
// It depends on nothing and is used by the top level, lwd_count and the testbench.
`default_nettype none

package lwd_pkg;

    localparam int EPOCH_W    = 4;
    localparam int OUT_TDATA_W = 16;

    localparam logic [4:0] MAGIC_LEN  = 5'd7;
    localparam logic [4:0] HEADER_END = 5'd15;
    localparam logic [4:0] MATCH_MIN  = 5'd3;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_FLAG   = 3'd1;
    localparam logic [2:0] PH_ITEM   = 3'd2;
    localparam logic [2:0] PH_MATCH2 = 3'd3;
    localparam logic [2:0] PH_DRAIN  = 3'd4;

    localparam logic [1:0] STAT_NONE  = 2'd0;
    localparam logic [1:0] STAT_DONE  = 2'd1;
    localparam logic [1:0] STAT_MAGIC = 2'd2;
    localparam logic [1:0] STAT_TRUNC = 2'd3;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic [1:0] sel;
        logic       inc;
    } cnt_ctrl_t;

    typedef struct packed {
        logic size_zero;
        logic hit_next;
    } cnt_stat_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        begin
            case (idx)
                3'd0:    val = 8'h52;
                3'd1:    val = 8'h43;
                3'd2:    val = 8'h4C;
                3'd3:    val = 8'h49;
                3'd4:    val = 8'h42;
                3'd5:    val = 8'h2D;
                3'd6:    val = 8'h4C;
                default: val = 8'h00;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lzss_window_decompressor.sv -----
// Top level of the LZSS decompressor with a history window: sequencer and output register.
// Depends on lwd_pkg, lwd_ram and lwd_count.
//
// The compressed stream enters one byte per word on the s_axis channel, with tlast on the
// final byte of each stream. Results leave on the m_axis channel: a decompressed byte
// (tuser high) or a status word (tuser low); tlast marks the last result of an input byte.
// One input byte is handled at a time and s_axis_tready stays low until its results have
// been handed to the output register. A literal byte goes from ST_DECODE to ST_COPY; a
// match runs ST_READ then ST_COPY for every copied byte, reading the window RAM in the
// first and emitting the byte and writing it back in the second. A status result goes
// through ST_STATUS. Window entries carry a stream tag, so a new stream sees a cleared
// window without a sweep. After reset, and after every sixteenth stream when the tag
// wraps, a clearing pass writes the whole window, one entry per cycle, while no input
// is taken. When the receiver stalls, the result waits in the output register and the
// sequencer pauses until that register frees up.
`default_nettype none

module lzss_window_decompressor #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // in_byte
    input  wire logic        s_axis_tlast,  // in_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // data_byte [7:0], status [9:8], zero fill
    output logic             m_axis_tuser,  // is_data
    output logic             m_axis_tlast   // run_last
);

    import lwd_pkg::*;

    localparam int WIN_AW = $clog2(WINDOW_DEPTH);
    localparam logic [WIN_AW-1:0] WIN_START = WIN_AW'(12'hFEE);
    localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WINDOW_DEPTH - 1);
    localparam int RAM_W = EPOCH_W + 8;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_COPY   = 3'd4;
    localparam logic [2:0] ST_STATUS = 3'd5;

    logic [2:0]         st_reg, st_next;
    logic [2:0]         phase_reg, phase_next;
    logic [4:0]         hdr_idx_reg, hdr_idx_next;
    logic [7:0]         flag_bits_reg, flag_bits_next;
    logic [3:0]         flags_left_reg, flags_left_next;
    logic [7:0]         low_reg, low_next;
    logic [WIN_AW-1:0]  wp_reg, wp_next;
    logic [WIN_AW-1:0]  src_reg, src_next;
    logic [4:0]         rem_reg, rem_next;
    logic               lit_reg, lit_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic [1:0]         stat_reg, stat_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [WIN_AW-1:0]  clr_addr_reg, clr_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_isdata_reg, out_isdata_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               ram_we;
    logic [WIN_AW-1:0]  ram_waddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [RAM_W-1:0]   ram_rdata;

    cnt_ctrl_t          cnt_ctrl;
    cnt_stat_t          cnt_stat;

    logic               can_emit;
    logic               emit;
    logic [7:0]         e_byte;
    logic               e_isdata;
    logic [1:0]         e_status;
    logic               e_last;
    logic [7:0]         cur_byte;
    logic [3:0]         fl_dec;

    lwd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    lwd_count u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cnt_ctrl),
        .load_byte (byte_reg),
        .stat      (cnt_stat)
    );

    assign can_emit      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (st_reg == ST_IDLE);
    assign cur_byte      = lit_reg ? byte_reg :
                           ((ram_rdata[RAM_W-1:8] == epoch_reg) ? ram_rdata[7:0] : 8'h00);
    assign fl_dec        = (flags_left_reg != 4'd0) ? (flags_left_reg - 4'd1) : 4'd0;

    always_comb
    begin
        logic go_copy;
        logic go_stat;
        logic fin;

        go_copy         = 1'b0;
        go_stat         = 1'b0;
        fin             = 1'b0;
        st_next         = st_reg;
        phase_next      = phase_reg;
        hdr_idx_next    = hdr_idx_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        low_next        = low_reg;
        wp_next         = wp_reg;
        src_next        = src_reg;
        rem_next        = rem_reg;
        lit_next        = lit_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        stat_next       = stat_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = {epoch_reg, cur_byte};
        ram_re          = 1'b0;
        cnt_ctrl        = '0;
        emit            = 1'b0;
        e_byte          = 8'h00;
        e_isdata        = 1'b0;
        e_status        = STAT_NONE;
        e_last          = 1'b0;

        case (st_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == WIN_LAST)
                begin
                    st_next    = ST_IDLE;
                    epoch_next = '0;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    byte_next = s_axis_tdata;
                    last_next = s_axis_tlast;
                    st_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (phase_reg)
                    PH_HEADER:
                    begin
                        if (hdr_idx_reg < MAGIC_LEN && byte_reg != magic_byte(hdr_idx_reg[2:0]))
                        begin
                            stat_next  = STAT_MAGIC;
                            phase_next = PH_DRAIN;
                            go_stat    = 1'b1;
                        end
                        else
                        begin
                            if (hdr_idx_reg[4:2] == 3'b010)
                            begin
                                cnt_ctrl.load = 1'b1;
                                cnt_ctrl.sel  = hdr_idx_reg[1:0];
                            end
                            hdr_idx_next = hdr_idx_reg + 5'd1;
                            if (hdr_idx_reg == HEADER_END)
                            begin
                                if (cnt_stat.size_zero)
                                begin
                                    stat_next  = STAT_DONE;
                                    phase_next = PH_DRAIN;
                                    go_stat    = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_FLAG;
                                end
                            end
                        end
                    end
                    PH_FLAG:
                    begin
                        flag_bits_next  = byte_reg;
                        flags_left_next = 4'd8;
                        phase_next      = PH_ITEM;
                    end
                    PH_ITEM:
                    begin
                        if (flag_bits_reg[7])
                        begin
                            low_next   = byte_reg;
                            phase_next = PH_MATCH2;
                        end
                        else
                        begin
                            lit_next = 1'b1;
                            rem_next = 5'd1;
                            st_next  = ST_COPY;
                            go_copy  = 1'b1;
                        end
                    end
                    PH_MATCH2:
                    begin
                        src_next = WIN_AW'({byte_reg[7:4], low_reg});
                        rem_next = {1'b0, byte_reg[3:0]} + MATCH_MIN;
                        lit_next = 1'b0;
                        st_next  = ST_READ;
                        go_copy  = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                if (!go_copy)
                begin
                    if (go_stat)
                    begin
                        st_next = ST_STATUS;
                    end
                    else if (last_reg && phase_next != PH_DRAIN)
                    begin
                        stat_next = STAT_TRUNC;
                        st_next   = ST_STATUS;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                ram_re  = 1'b1;
                st_next = ST_COPY;
            end
            ST_COPY:
            begin
                if (can_emit)
                begin
                    emit         = 1'b1;
                    e_byte       = cur_byte;
                    e_isdata     = 1'b1;
                    e_last       = !cnt_stat.hit_next && rem_reg == 5'd1 && !last_reg;
                    ram_we       = 1'b1;
                    wp_next      = wp_reg + 1'b1;
                    cnt_ctrl.inc = 1'b1;
                    src_next     = src_reg + 1'b1;
                    rem_next     = rem_reg - 5'd1;
                    if (cnt_stat.hit_next)
                    begin
                        phase_next = PH_DRAIN;
                        stat_next  = STAT_DONE;
                        st_next    = ST_STATUS;
                    end
                    else if (rem_reg == 5'd1)
                    begin
                        flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
                        flags_left_next = fl_dec;
                        phase_next      = (fl_dec != 4'd0) ? PH_ITEM : PH_FLAG;
                        if (last_reg)
                        begin
                            stat_next = STAT_TRUNC;
                            st_next   = ST_STATUS;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    else
                    begin
                        st_next = ST_READ;
                    end
                end
            end
            ST_STATUS:
            begin
                if (can_emit)
                begin
                    emit     = 1'b1;
                    e_status = stat_reg;
                    e_last   = 1'b1;
                    fin      = 1'b1;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            st_next = ST_IDLE;
            if (last_reg)
            begin
                wp_next         = WIN_START;
                hdr_idx_next    = '0;
                flag_bits_next  = '0;
                flags_left_next = '0;
                low_next        = '0;
                phase_next      = PH_HEADER;
                cnt_ctrl.clear  = 1'b1;
                epoch_next      = epoch_reg + 1'b1;
                clr_addr_next   = '0;
                if (epoch_reg == {EPOCH_W{1'b1}})
                begin
                    st_next = ST_CLEAR;
                end
            end
        end

        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_isdata_next = out_isdata_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = e_byte;
            out_isdata_next = e_isdata;
            out_status_next = e_status;
            out_last_next   = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_CLEAR;
            phase_reg      <= PH_HEADER;
            hdr_idx_reg    <= '0;
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            low_reg        <= '0;
            wp_reg         <= WIN_START;
            src_reg        <= '0;
            rem_reg        <= '0;
            lit_reg        <= 1'b0;
            byte_reg       <= '0;
            last_reg       <= 1'b0;
            stat_reg       <= STAT_NONE;
            epoch_reg      <= '0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_isdata_reg <= 1'b0;
            out_status_reg <= STAT_NONE;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            phase_reg      <= phase_next;
            hdr_idx_reg    <= hdr_idx_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            low_reg        <= low_next;
            wp_reg         <= wp_next;
            src_reg        <= src_next;
            rem_reg        <= rem_next;
            lit_reg        <= lit_next;
            byte_reg       <= byte_next;
            last_reg       <= last_next;
            stat_reg       <= stat_next;
            epoch_reg      <= epoch_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_isdata_reg <= out_isdata_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 10){1'b0}}, out_status_reg, out_byte_reg};
    assign m_axis_tuser  = out_isdata_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_ram_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("Window RAM read and write in the same cycle.");

    a_copy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_READ || st_reg == ST_COPY) |-> rem_reg != 5'd0)
        else $error("Copy loop running with no bytes left.");

    a_done_follows_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_COPY && can_emit && cnt_stat.hit_next)
        |=> (st_reg == ST_STATUS && stat_reg == STAT_DONE && phase_reg == PH_DRAIN))
        else $error("Output size reached without a completion status.");

    a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= 5'd16)
        else $error("Header index ran past the header.");

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_isdata_reg) |-> (out_last_reg && out_status_reg != STAT_NONE))
        else $error("Status word without a status or not ending its run.");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lwd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module lwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lwd_count.sv -----
// Output byte counter and expected size register with the shared increment and compare.
// Depends on lwd_pkg.
`default_nettype none

module lwd_count (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lwd_pkg::cnt_ctrl_t ctrl,
    input  wire logic [7:0]         load_byte,
    output lwd_pkg::cnt_stat_t      stat
);

    import lwd_pkg::*;

    logic [31:0] cnt_reg;
    logic [31:0] cnt_next;
    logic [31:0] exp_reg;
    logic [31:0] exp_next;
    logic [31:0] cnt_plus;

    assign cnt_plus = cnt_reg + 32'd1;

    always_comb
    begin
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        if (ctrl.clear)
        begin
            cnt_next = '0;
            exp_next = '0;
        end
        else
        begin
            if (ctrl.inc)
            begin
                cnt_next = cnt_plus;
            end
            if (ctrl.load)
            begin
                case (ctrl.sel)
                    2'd0:    exp_next[7:0]   = exp_reg[7:0]   | load_byte;
                    2'd1:    exp_next[15:8]  = exp_reg[15:8]  | load_byte;
                    2'd2:    exp_next[23:16] = exp_reg[23:16] | load_byte;
                    default: exp_next[31:24] = exp_reg[31:24] | load_byte;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            exp_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

    assign stat.size_zero = (exp_reg == 32'd0);
    assign stat.hit_next  = (cnt_plus == exp_reg);

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for lzss_window_decompressor: a directed table of short streams,
// then random streams, all checked against a behavioral decoder kept in this file.
// Depends on lwd_pkg and the decompressor RTL; random stalls and gaps on both stream sides.
module tb_top;
    import lwd_pkg::*;

    localparam logic [55:0] MAGIC_TEXT = "RCLIB-L";
    localparam int RANDOM_WORDS = 260;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic [7:0] data;
        logic       is_data;
        logic [1:0] stat;
        logic       last;
    } out_word_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        logic [1:0] stat;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_last = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;
    logic        m_user;
    logic        m_last;

    // Decoder state.
    logic [7:0]  win_mem [4096];
    logic [11:0] win_ptr;
    logic [31:0] out_count;
    logic [31:0] out_total;
    logic [4:0]  hdr_pos;
    logic [7:0]  flag_reg;
    logic [3:0]  flag_cnt;
    logic [7:0]  match_lo;
    logic [2:0]  phase;

    out_word_t   pending_out [$];
    out_word_t   seen_word;
    row_t        rows [$];
    int          fail_count = 0;
    int          stream_words = 0;
    logic        tx_quiet = 1'b0;
    logic        rx_quiet = 1'b0;
    logic        hold_req = 1'b0;
    logic [3:0]  pend_hi;

    lzss_window_decompressor #(
        .WINDOW_DEPTH(4096)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .m_axis_tlast  (m_last)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] magic_at(input int idx);
        return MAGIC_TEXT[55 - 8 * idx -: 8];
    endfunction

    task automatic reset_model();
        foreach (win_mem[i])
            win_mem[i] = 8'h00;
        win_ptr   = 12'hFEE;
        out_count = 32'd0;
        out_total = 32'd0;
        hdr_pos   = 5'd0;
        flag_reg  = 8'h00;
        flag_cnt  = 4'd0;
        match_lo  = 8'h00;
        phase     = PH_HEADER;
    endtask

    task automatic push_result(input logic [7:0] data, input logic is_data,
                               input logic [1:0] stat);
        out_word_t w;
        w.data = data;
        w.is_data = is_data;
        w.stat = stat;
        w.last = 1'b0;
        pending_out.insert(pending_out.size(), w);
    endtask

    task automatic emit_byte(input logic [7:0] c);
        push_result(c, 1'b1, STAT_NONE);
        win_mem[win_ptr] = c;
        win_ptr = win_ptr + 12'd1;
        out_count = out_count + 32'd1;
        if (out_count == out_total)
        begin
            push_result(8'h00, 1'b0, STAT_DONE);
            phase = PH_DRAIN;
        end
    endtask

    task automatic next_flag();
        flag_reg = flag_reg << 1;
        if (flag_cnt != 4'd0)
            flag_cnt = flag_cnt - 4'd1;
        phase = (flag_cnt != 4'd0) ? PH_ITEM : PH_FLAG;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        int first;
        int i;
        int run_len;
        logic [11:0] src;
        first = pending_out.size();
        case (phase)
            PH_HEADER:
            begin
                if (hdr_pos < 5'd7 && b != magic_at(hdr_pos))
                begin
                    push_result(8'h00, 1'b0, STAT_MAGIC);
                    phase = PH_DRAIN;
                end
                else
                begin
                    if (hdr_pos >= 5'd8 && hdr_pos < 5'd12)
                        out_total[8 * (int'(hdr_pos) - 8) +: 8] = b;
                    hdr_pos = hdr_pos + 5'd1;
                    if (hdr_pos == 5'd16)
                    begin
                        if (out_total == 32'd0)
                        begin
                            push_result(8'h00, 1'b0, STAT_DONE);
                            phase = PH_DRAIN;
                        end
                        else
                            phase = PH_FLAG;
                    end
                end
            end
            PH_FLAG:
            begin
                flag_reg = b;
                flag_cnt = 4'd8;
                phase = PH_ITEM;
            end
            PH_ITEM:
            begin
                if (flag_reg[7])
                begin
                    match_lo = b;
                    phase = PH_MATCH2;
                end
                else
                begin
                    emit_byte(b);
                    if (phase != PH_DRAIN)
                        next_flag();
                end
            end
            PH_MATCH2:
            begin
                src = {b[7:4], match_lo};
                run_len = int'(b[3:0]) + 3;
                for (i = 0; i < run_len && phase != PH_DRAIN; i++)
                    emit_byte(win_mem[(int'(src) + i) % 4096]);
                if (phase != PH_DRAIN)
                    next_flag();
            end
            default:
            begin
            end
        endcase
        if (last)
        begin
            if (phase != PH_DRAIN)
                push_result(8'h00, 1'b0, STAT_TRUNC);
            reset_model();
        end
        if (pending_out.size() > first)
            pending_out[pending_out.size() - 1].last = 1'b1;
    endtask

    // Offers one word, waits for it to be taken, then updates the expected results.
    // A typed word replaces the decoder's results with the status given by hand, or with none for STAT_NONE.
    task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                             input logic [1:0] stat);
        int gap;
        int first;
        out_word_t w;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= last;
        do @(posedge clk); while (!s_ready);
        if (phase != PH_DRAIN)
            stream_words++;
        first = pending_out.size();
        decode_byte(b, last);
        if (typed)
        begin
            while (pending_out.size() > first)
                void'(pending_out.pop_back());
            if (stat != STAT_NONE)
            begin
                w.data = 8'h00;
                w.is_data = 1'b0;
                w.stat = stat;
                w.last = 1'b1;
                pending_out.insert(pending_out.size(), w);
            end
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic last, input logic typed,
                           input logic [1:0] stat);
        row_t r;
        r.b = b;
        r.last = last;
        r.typed = typed;
        r.stat = stat;
        rows.insert(rows.size(), r);
    endtask

    // One random stream. Most are well formed, with body words chosen from the decoder's
    // phase so flags, literals and matches line up; others corrupt the header or end early.
    task automatic run_stream();
        int kind;
        int stop_at;
        int extra;
        int body_left;
        int i;
        logic [31:0] size;
        logic [11:0] src;
        logic [7:0] b;
        logic stop;
        kind = $urandom_range(0, 9);
        tx_quiet = ($urandom_range(0, 3) == 0);
        size = ($urandom_range(0, 7) != 0) ? $urandom_range(1, 48) : $urandom_range(49, 400);
        if (kind == 7)
            size = $urandom;
        stop_at = 99;
        if (kind == 8)
            stop_at = $urandom_range(0, 6);
        else if (kind == 9)
            stop_at = $urandom_range(0, 14);
        for (i = 0; i < 16; i++)
        begin
            if (i < 7)
                b = magic_at(i);
            else if (i >= 8 && i < 12)
                b = size[8 * (i - 8) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            if (kind == 8 && i == stop_at)
            begin
                b = b ^ 8'($urandom_range(1, 255));
                stop_at = stop_at + $urandom_range(0, 3);
            end
            send_word(b, i == stop_at, 1'b0, STAT_NONE);
            if (i == stop_at)
                return;
        end
        extra = $urandom_range(0, 3);
        body_left = (kind == 7) ? $urandom_range(0, 40) : -1;
        stop = 1'b0;
        while (!stop)
        begin
            b = 8'($urandom_range(0, 255));
            if (phase == PH_ITEM && flag_reg[7])
            begin
                if ($urandom_range(0, 4) == 0)
                    src = 12'($urandom_range(0, 4095));
                else
                    src = win_ptr - 12'($urandom_range(1, 64));
                pend_hi = src[11:8];
                b = src[7:0];
            end
            else if (phase == PH_MATCH2)
                b = {pend_hi, 4'($urandom_range(0, 15))};
            if (phase == PH_DRAIN)
            begin
                stop = (extra == 0);
                extra--;
            end
            else
            begin
                stop = (body_left == 0) || (stream_words + 1 >= RANDOM_WORDS);
                body_left--;
            end
            send_word(b, stop, 1'b0, STAT_NONE);
        end
    endtask

    initial
    begin : stimulus
        int k;
        int streams;
        reset_model();
        for (k = 0; k < 6; k++)
            add_row(magic_at(k), 1'b0, 1'b0, STAT_NONE);
        add_row(8'hFF, 1'b1, 1'b1, STAT_MAGIC);
        add_row(magic_at(0), 1'b1, 1'b1, STAT_TRUNC);
        for (k = 0; k < 7; k++)
            add_row(magic_at(k), 1'b0, 1'b0, STAT_NONE);
        add_row(8'hFF, 1'b0, 1'b1, STAT_NONE);
        for (k = 8; k < 12; k++)
            add_row(8'h00, 1'b0, 1'b1, STAT_NONE);
        for (k = 12; k < 15; k++)
            add_row(8'hFF, 1'b0, 1'b1, STAT_NONE);
        add_row(8'h00, 1'b1, 1'b1, STAT_DONE);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (k = 0; k < rows.size(); k++)
            send_word(rows[k].b, rows[k].last, rows[k].typed, rows[k].stat);

        stream_words = 0;
        streams = 0;
        while (stream_words < RANDOM_WORDS)
        begin
            if (streams == 2)
                hold_req = 1'b1;
            run_stream();
            streams++;
        end
        s_valid <= 1'b0;

        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
                stall = rx_quiet ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0)
                rx_quiet = !rx_quiet;
            if (stall > 0)
            begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_ready <= 1'b1;
            do @(posedge clk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_valid && m_ready)
        begin
            if (pending_out.size() == 0)
            begin
                $error("unexpected word: data_byte %0h is_data %0b status %0d run_last %0b",
                       m_data[7:0], m_user, m_data[9:8], m_last);
                fail_count++;
            end
            else
            begin
                seen_word = pending_out.pop_front();
                if (m_data[7:0] !== seen_word.data)
                begin
                    $error("data_byte: expected %0h, got %0h", seen_word.data, m_data[7:0]);
                    fail_count++;
                end
                if (m_user !== seen_word.is_data)
                begin
                    $error("is_data: expected %0b, got %0b", seen_word.is_data, m_user);
                    fail_count++;
                end
                if (m_data[9:8] !== seen_word.stat)
                begin
                    $error("status: expected %0d, got %0d", seen_word.stat, m_data[9:8]);
                    fail_count++;
                end
                if (m_last !== seen_word.last)
                begin
                    $error("run_last: expected %0b, got %0b", seen_word.last, m_last);
                    fail_count++;
                end
            end
        end
    end

endmodule
